[rtl/pifmt_pkg.sv]
package pifmt_pkg;

  // conversion kinds (tuser[2:0] on the input side)
  localparam logic [2:0] CMD_BIN  = 3'd0;
  localparam logic [2:0] CMD_OCT  = 3'd1;
  localparam logic [2:0] CMD_DEC  = 3'd2;
  localparam logic [2:0] CMD_UNS  = 3'd3;
  localparam logic [2:0] CMD_HEX  = 3'd4;
  localparam logic [2:0] CMD_HEXU = 3'd5;
  localparam logic [2:0] CMD_PTR  = 3'd6;

  // length modifier that selects a 16-bit operand
  localparam logic [1:0] LM_SHORT = 2'd1;
  localparam int unsigned SHORT_BITS = 16;

  // stream widths
  localparam int unsigned S_TDATA_W = 56;
  localparam int unsigned S_TUSER_W = 5;
  localparam int unsigned M_TDATA_W = 8;

  // digit store
  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned STORE_AW    = 6;
  localparam int unsigned FIELD_CW    = 7;  // counts 0..64

  localparam logic [5:0] PREC_MAX     = 6'd62;
  localparam logic [5:0] PREC_DEFAULT = 6'd1;
  localparam logic [3:0] DIGIT_TEN    = 4'd10;
  localparam logic [3:0] BCD_FIVE     = 4'd5;
  localparam logic [3:0] BCD_ADJ      = 4'd3;

  // characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;

endpackage

[rtl/printf_integer_field_formatter.sv]
// Integer field formatter for printf-style output. Each input word carries one parsed
// integer conversion (b, o, d/i, u, x, X, p), its length modifier, the raw argument bits,
// the flags, width and precision; the block sends the formatted field out one ASCII
// character per output word, with tlast on the final character. A field of width zero
// with nothing to print sends no word, and neither does the unused conversion code 7.
// Digits are produced serially: for decimal the magnitude is first turned into BCD by a
// shift-and-add-3 pass over the VALUE_BITS bits, one bit per cycle; then every conversion
// peels one digit per cycle off a shift register into a 64-entry digit store (plus the
// octal alternate zero, when added), sees the digits done, sets up the field layout, and
// reads the store back most significant digit first, one character per cycle while the
// output side is ready. A new item is taken once the previous field's last character has
// been loaded into the output register, so the next conversion overlaps that final
// hand-off.
module printf_integer_field_formatter #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAX_FIELD  = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [31:0] value, [32] left_justify, [33] force_sign, [34] space_sign,
  // [35] alternate, [36] zero_fill, [43:37] width, [44] precision_given,
  // [50:45] precision, [55:51] zero
  input  logic [pifmt_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // [2:0] command, [4:3] length_mod
  input  logic [pifmt_pkg::S_TUSER_W-1:0]   s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [7:0] out_char
  output logic [pifmt_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  // last
  output logic                              m_axis_tlast_o
);

  localparam int unsigned BCD_DIGITS = (VALUE_BITS * 3) / 10 + 1;
  localparam int unsigned REM_W      = 4 * BCD_DIGITS;
  localparam int unsigned CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int unsigned FW         = pifmt_pkg::FIELD_CW;
  localparam int unsigned AW         = pifmt_pkg::STORE_AW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_DIGIT,
    ST_PREP,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    RAD_BIN,
    RAD_OCT,
    RAD_DEC,
    RAD_HEX
  } radix_e;

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  state_e                state_q, state_d;
  radix_e                radix_q, radix_d;
  logic                  upper_q, upper_d;
  logic                  oct_alt_q, oct_alt_d;
  logic                  lj_q, lj_d;
  logic                  zf_q, zf_d;
  logic [FW-1:0]         width_q, width_d;
  logic [5:0]            prec_q, prec_d;
  logic [1:0]            hlen_q, hlen_d;
  logic [7:0]            head0_q, head0_d;
  logic [7:0]            head1_q, head1_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [REM_W-1:0]      remaining_q, remaining_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [FW-1:0]         n_q, n_d;
  logic                  top_zero_q, top_zero_d;
  logic [FW-1:0]         b1_q, b1_d;
  logic [FW-1:0]         b2_q, b2_d;
  logic [FW-1:0]         b3_q, b3_d;
  logic [FW-1:0]         b4_q, b4_d;
  logic [FW-1:0]         total_q, total_d;
  logic [FW-1:0]         pos_q, pos_d;
  logic [FW-1:0]         dptr_q, dptr_d;
  logic                  m_valid_q, m_valid_d;
  logic [7:0]            m_data_q, m_data_d;
  logic                  m_last_q, m_last_d;

  // digit store
  logic [7:0]            digit_store_q [pifmt_pkg::STORE_DEPTH];
  logic [7:0]            rd_data_q;
  logic                  st_we;
  logic [AW-1:0]         st_waddr;
  logic [7:0]            st_wdata;

  // ---------------------------------------------------------------------------
  // input decode
  // ---------------------------------------------------------------------------
  logic [2:0]            in_cmd;
  logic                  in_short;
  logic [VALUE_BITS-1:0] in_val;
  logic [VALUE_BITS-1:0] in_neg;
  logic                  in_is_neg;
  logic [VALUE_BITS-1:0] in_mag;
  logic                  in_mag_nz;
  logic                  in_pg;
  logic [5:0]            in_prec;
  logic [FW-1:0]         in_width;
  logic                  in_alt;
  logic                  in_upper;

  assign in_cmd   = s_axis_tuser_i[2:0];
  assign in_short = (s_axis_tuser_i[4:3] == pifmt_pkg::LM_SHORT);
  assign in_alt   = s_axis_tdata_i[35];
  assign in_pg    = s_axis_tdata_i[44];
  assign in_prec  = s_axis_tdata_i[50:45];
  assign in_width = s_axis_tdata_i[43:37];
  assign in_upper = (in_cmd == pifmt_pkg::CMD_HEXU);

  always_comb begin
    if (in_short) begin
      in_val    = VALUE_BITS'(s_axis_tdata_i[15:0]);
      in_neg    = VALUE_BITS'(16'(~s_axis_tdata_i[15:0] + 16'd1));
      in_is_neg = s_axis_tdata_i[15];
    end else begin
      in_val    = VALUE_BITS'(s_axis_tdata_i[31:0]);
      in_neg    = ~in_val + VALUE_BITS'(1);
      in_is_neg = in_val[VALUE_BITS-1];
    end
    in_is_neg = in_is_neg && (in_cmd == pifmt_pkg::CMD_DEC);
    in_mag    = in_is_neg ? in_neg : in_val;
    in_mag_nz = |in_mag;
  end

  // ---------------------------------------------------------------------------
  // shared datapath pieces
  // ---------------------------------------------------------------------------
  logic [REM_W-1:0] dabbled;
  logic [3:0]       dig;
  logic [7:0]       dig_char;
  logic             more_digits;
  logic             out_free;
  logic             load_out;
  logic             is_last;
  logic             dig_emit;
  logic [7:0]       emit_char;
  logic [FW-1:0]    len_c;
  logic [FW-1:0]    pad_c;
  logic [FW-1:0]    b1_c;
  logic [FW-1:0]    b2_c;
  logic [FW-1:0]    b3_c;
  logic [FW-1:0]    b4_c;

  // add-3 correction on every BCD lane before the next shift
  always_comb begin
    for (int j = 0; j < BCD_DIGITS; j++) begin
      dabbled[4*j +: 4] = (remaining_q[4*j +: 4] >= pifmt_pkg::BCD_FIVE)
                        ? remaining_q[4*j +: 4] + pifmt_pkg::BCD_ADJ
                        : remaining_q[4*j +: 4];
    end
  end

  always_comb begin
    unique case (radix_q)
      RAD_BIN: dig = {3'b000, remaining_q[0]};
      RAD_OCT: dig = {1'b0, remaining_q[2:0]};
      default: dig = remaining_q[3:0];
    endcase
    if (dig < pifmt_pkg::DIGIT_TEN) begin
      dig_char = pifmt_pkg::CH_ZERO + 8'(dig);
    end else begin
      dig_char = (upper_q ? pifmt_pkg::CH_UP_A : pifmt_pkg::CH_LO_A)
               + 8'(dig - pifmt_pkg::DIGIT_TEN);
    end
  end

  assign more_digits = ((|remaining_q) || (n_q < {1'b0, prec_q}))
                    && (n_q < FW'(pifmt_pkg::STORE_DEPTH));

  // field layout: [lead spaces][head][zero fill][digits][trail spaces]
  always_comb begin
    len_c = FW'(hlen_q) + n_q;
    pad_c = (width_q > len_c) ? width_q - len_c : '0;
    b1_c  = (!lj_q && !zf_q) ? pad_c : '0;
    b2_c  = b1_c + FW'(hlen_q);
    b3_c  = b2_c + (zf_q ? pad_c : '0);
    b4_c  = b3_c + n_q;
  end

  always_comb begin
    dig_emit = 1'b0;
    if (pos_q < b1_q) begin
      emit_char = pifmt_pkg::CH_SPACE;
    end else if (pos_q < b2_q) begin
      emit_char = (pos_q == b1_q) ? head0_q : head1_q;
    end else if (pos_q < b3_q) begin
      emit_char = pifmt_pkg::CH_ZERO;
    end else if (pos_q < b4_q) begin
      emit_char = rd_data_q;
      dig_emit  = 1'b1;
    end else begin
      emit_char = pifmt_pkg::CH_SPACE;
    end
  end

  assign out_free = !m_valid_q || m_axis_tready_i;
  assign load_out = (state_q == ST_EMIT) && out_free;
  assign is_last  = (pos_q == total_q - FW'(1));

  // ---------------------------------------------------------------------------
  // next-state logic
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    radix_d     = radix_q;
    upper_d     = upper_q;
    oct_alt_d   = oct_alt_q;
    lj_d        = lj_q;
    zf_d        = zf_q;
    width_d     = width_q;
    prec_d      = prec_q;
    hlen_d      = hlen_q;
    head0_d     = head0_q;
    head1_d     = head1_q;
    bin_d       = bin_q;
    remaining_d = remaining_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    top_zero_d  = top_zero_q;
    b1_d        = b1_q;
    b2_d        = b2_q;
    b3_d        = b3_q;
    b4_d        = b4_q;
    total_d     = total_q;
    pos_d       = pos_q;
    dptr_d      = dptr_q;
    m_valid_d   = m_valid_q && !m_axis_tready_i;
    m_data_d    = m_data_q;
    m_last_d    = m_last_q;
    st_we       = 1'b0;
    st_waddr    = n_q[AW-1:0];
    st_wdata    = dig_char;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          upper_d     = in_upper;
          oct_alt_d   = (in_cmd == pifmt_pkg::CMD_OCT) && in_alt;
          lj_d        = s_axis_tdata_i[32];
          zf_d        = s_axis_tdata_i[36] && !s_axis_tdata_i[32] && !in_pg;
          width_d     = (in_width > FW'(MAX_FIELD)) ? FW'(MAX_FIELD) : in_width;
          prec_d      = !in_pg ? pifmt_pkg::PREC_DEFAULT
                      : ((in_prec > pifmt_pkg::PREC_MAX) ? pifmt_pkg::PREC_MAX : in_prec);
          n_d         = '0;
          top_zero_d  = 1'b0;
          cnt_d       = '0;
          bin_d       = in_mag;
          remaining_d = REM_W'(in_mag);
          // sign, then a hex prefix that replaces it for nonzero values
          hlen_d      = 2'd0;
          head0_d     = pifmt_pkg::CH_SPACE;
          head1_d     = in_upper ? pifmt_pkg::CH_UP_X : pifmt_pkg::CH_LO_X;
          if (in_is_neg) begin
            hlen_d  = 2'd1;
            head0_d = pifmt_pkg::CH_MINUS;
          end else if (in_cmd == pifmt_pkg::CMD_DEC && s_axis_tdata_i[33]) begin
            hlen_d  = 2'd1;
            head0_d = pifmt_pkg::CH_PLUS;
          end else if (in_cmd == pifmt_pkg::CMD_DEC && s_axis_tdata_i[34]) begin
            hlen_d  = 2'd1;
            head0_d = pifmt_pkg::CH_SPACE;
          end
          if (in_mag_nz && ((in_alt && (in_cmd == pifmt_pkg::CMD_HEX
                                     || in_cmd == pifmt_pkg::CMD_HEXU))
                            || in_cmd == pifmt_pkg::CMD_PTR)) begin
            hlen_d  = 2'd2;
            head0_d = pifmt_pkg::CH_ZERO;
          end
          unique case (in_cmd) inside
            pifmt_pkg::CMD_BIN: begin
              radix_d = RAD_BIN;
              state_d = ST_DIGIT;
            end
            pifmt_pkg::CMD_OCT: begin
              radix_d = RAD_OCT;
              state_d = ST_DIGIT;
            end
            pifmt_pkg::CMD_DEC, pifmt_pkg::CMD_UNS: begin
              radix_d     = RAD_DEC;
              remaining_d = '0;
              state_d     = ST_CONV;
            end
            pifmt_pkg::CMD_HEX, pifmt_pkg::CMD_HEXU, pifmt_pkg::CMD_PTR: begin
              radix_d = RAD_HEX;
              state_d = ST_DIGIT;
            end
            default: state_d = ST_IDLE;  // unused code: no output
          endcase
        end
      end

      ST_CONV: begin
        remaining_d = {dabbled[REM_W-2:0], bin_q[VALUE_BITS-1]};
        bin_d       = {bin_q[VALUE_BITS-2:0], 1'b0};
        cnt_d       = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
          state_d = ST_DIGIT;
        end
      end

      ST_DIGIT: begin
        if (more_digits) begin
          st_we      = 1'b1;
          n_d        = n_q + FW'(1);
          top_zero_d = (dig == 4'd0);
          unique case (radix_q)
            RAD_BIN: remaining_d = remaining_q >> 1;
            RAD_OCT: remaining_d = remaining_q >> 3;
            default: remaining_d = remaining_q >> 4;
          endcase
        end else if (oct_alt_q && n_q < FW'(pifmt_pkg::STORE_DEPTH)
                     && (n_q == '0 || !top_zero_q)) begin
          // octal alternate form: leading zero unless one is there already
          st_we      = 1'b1;
          st_wdata   = pifmt_pkg::CH_ZERO;
          n_d        = n_q + FW'(1);
          top_zero_d = 1'b1;
        end else begin
          state_d = ST_PREP;
        end
      end

      ST_PREP: begin
        b1_d    = b1_c;
        b2_d    = b2_c;
        b3_d    = b3_c;
        b4_d    = b4_c;
        total_d = b4_c + (lj_q ? pad_c : '0);
        pos_d   = '0;
        dptr_d  = n_q - FW'(1);
        state_d = ((b4_c + (lj_q ? pad_c : '0)) == '0) ? ST_IDLE : ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = emit_char;
          m_last_d  = is_last;
          pos_d     = pos_q + FW'(1);
          if (dig_emit) begin
            dptr_d = dptr_q - FW'(1);
          end
          if (is_last) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radix_q     <= RAD_BIN;
      upper_q     <= 1'b0;
      oct_alt_q   <= 1'b0;
      lj_q        <= 1'b0;
      zf_q        <= 1'b0;
      width_q     <= '0;
      prec_q      <= '0;
      hlen_q      <= '0;
      head0_q     <= '0;
      head1_q     <= '0;
      bin_q       <= '0;
      remaining_q <= '0;
      cnt_q       <= '0;
      n_q         <= '0;
      top_zero_q  <= 1'b0;
      b1_q        <= '0;
      b2_q        <= '0;
      b3_q        <= '0;
      b4_q        <= '0;
      total_q     <= '0;
      pos_q       <= '0;
      dptr_q      <= '0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
      m_last_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      radix_q     <= radix_d;
      upper_q     <= upper_d;
      oct_alt_q   <= oct_alt_d;
      lj_q        <= lj_d;
      zf_q        <= zf_d;
      width_q     <= width_d;
      prec_q      <= prec_d;
      hlen_q      <= hlen_d;
      head0_q     <= head0_d;
      head1_q     <= head1_d;
      bin_q       <= bin_d;
      remaining_q <= remaining_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      top_zero_q  <= top_zero_d;
      b1_q        <= b1_d;
      b2_q        <= b2_d;
      b3_q        <= b3_d;
      b4_q        <= b4_d;
      total_q     <= total_d;
      pos_q       <= pos_d;
      dptr_q      <= dptr_d;
      m_valid_q   <= m_valid_d;
      m_data_q    <= m_data_d;
      m_last_q    <= m_last_d;
    end
  end

  // digit store: one write port, one registered read port addressed by the next
  // pointer value so the next digit is waiting when it is needed
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      digit_store_q[st_waddr] <= st_wdata;
    end
    rd_data_q <= digit_store_q[dptr_d[AW-1:0]];
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= FW'(pifmt_pkg::STORE_DEPTH))
    else $error("digit count past store depth");

  a_pos_in_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> pos_q < total_q)
    else $error("emit position past field end");

  a_digit_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && dig_emit) |-> dptr_q < n_q)
    else $error("digit read outside written entries");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && is_last) |=> (state_q == ST_IDLE && m_axis_tlast_o && m_axis_tvalid_o))
    else $error("last character did not close the field");

endmodule
